@@ hw/rtl/pronoun_word_substitution_filter_macros.svh @@
// Assertion helpers used by the filter RTL.
`ifndef PRONOUN_WORD_SUBSTITUTION_FILTER_MACROS_SVH
`define PRONOUN_WORD_SUBSTITUTION_FILTER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PWSF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PWSF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/pwsf_pkg.sv @@
package pwsf_pkg;

   // Output cap per message, in bytes
   localparam logic [10:0] MAX_LEN = 11'd1280;

   // Lookahead window
   localparam int          WIN_DEPTH = 8;
   localparam logic [3:0]  WIN_FULL  = 4'd8;

   // Control code range
   localparam logic [7:0]  CTRL_FIRST = 8'h01;
   localparam logic [7:0]  CTRL_LAST  = 8'h1F;

   // Mode codes (3 behaves as the they forms)
   localparam logic [1:0]  MODE_PASS = 2'd0;
   localparam logic [1:0]  MODE_SHE  = 2'd1;

   localparam int          NUM_PAT = 8;

   // Strings are left justified, one char per byte, padded with spaces
   localparam logic [63:0] PAT_FROM [NUM_PAT] = '{
      "Himself ", "himself ", "Him     ", "him     ",
      "His     ", "his     ", "He      ", "he      "
   };
   localparam logic [3:0]  PAT_FLEN [NUM_PAT] = '{
      4'd7, 4'd7, 4'd3, 4'd3, 4'd3, 4'd3, 4'd2, 4'd2
   };
   localparam logic [63:0] PAT_SHE [NUM_PAT] = '{
      "Herself ", "herself ", "Her     ", "her     ",
      "Her     ", "her     ", "She     ", "she     "
   };
   localparam logic [3:0]  PAT_SLEN [NUM_PAT] = '{
      4'd7, 4'd7, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3
   };
   localparam logic [63:0] PAT_THEY [NUM_PAT] = '{
      "Themself", "themself", "Them    ", "them    ",
      "Their   ", "their   ", "They    ", "they    "
   };
   localparam logic [3:0]  PAT_TLEN [NUM_PAT] = '{
      4'd8, 4'd8, 4'd4, 4'd4, 4'd5, 4'd5, 4'd4, 4'd4
   };

   // Argument bytes that follow each control code
   localparam logic [1:0]  ARG_TABLE [32] = '{
      2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2,
      2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd0, 2'd1, 2'd0,
      2'd0, 2'd2, 2'd2, 2'd1, 2'd1, 2'd3, 2'd0, 2'd0,
      2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd0
   };

   // One output word: byte plus end-of-message mark
   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } word_type;

   function automatic logic is_letter(input logic [7:0] c);
      return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
   endfunction

   // Character idx of a left-justified string
   function automatic logic [7:0] pat_char(input logic [63:0] str, input logic [2:0] idx);
      logic [2:0] pos;
      pos = 3'd7 - idx;
      return str[{pos, 3'b000} +: 8];
   endfunction

   // Replacement string for a pattern under the given mode
   function automatic logic [63:0] rep_str(input logic [2:0] pat, input logic [1:0] mode);
      return (mode == MODE_SHE) ? PAT_SHE[pat] : PAT_THEY[pat];
   endfunction

endpackage

@@ hw/rtl/pronoun_word_substitution_filter.sv @@
// Rewrites a message one byte per word, replacing masculine pronouns by the she or they
// forms chosen in csr_pronoun_mode (latched at the first byte of each message). While the
// output queue has room, plain text flows at one byte per cycle once the eight-byte
// lookahead window has filled, so output trails input by eight bytes within a message.
// A replacement gives one output byte per step and holds the input until its last byte.
// The word that carries the message end holds the input while the window drains, one
// output byte per cycle while the queue has room. Pass-through messages move one byte per
// cycle with no lookahead while the queue has room. Results leave through a two-word
// output queue, so the input keeps moving while a finished byte waits on rsp_ready.
`include "pronoun_word_substitution_filter_macros.svh"

module pronoun_word_substitution_filter (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_pronoun_mode,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic [10:0] req_msg_length,
   input  logic        req_in_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_out_last
);

   // Configuration and per-message state
   logic [1:0]  csr_mode_ff;
   logic [1:0]  mode_ff, mode_in;
   logic        in_msg_ff, in_msg_in;
   logic        pass_ff, pass_in;
   logic        flush_ff, flush_in;
   logic        prev_ff, prev_in;
   logic [1:0]  args_ff, args_in;
   logic [10:0] ocnt_ff, ocnt_in;

   // Lookahead window
   logic [7:0]  win_ff [pwsf_pkg::WIN_DEPTH];
   logic [7:0]  win_in [pwsf_pkg::WIN_DEPTH];
   logic [3:0]  fill_ff, fill_in, fill_after;

   // Replacement in progress
   logic        rep_ff, rep_in;
   logic [2:0]  rep_pat_ff, rep_pat_in;
   logic [2:0]  rep_idx_ff, rep_idx_in;
   logic [3:0]  rep_len_ff, rep_len_in;

   // Output queue
   pwsf_pkg::word_type fq_ff [2];
   logic        wr_ptr_ff, rd_ptr_ff;
   logic [1:0]  fq_cnt_ff;
   logic        push, fq_pop, room;
   pwsf_pkg::word_type push_word;

   // Step decode
   logic [pwsf_pkg::NUM_PAT-1:0] pat_ok;
   logic        hit;
   logic [2:0]  hit_pat;
   logic [7:0]  head;
   logic        head_ctrl;
   logic [3:0]  tl;
   logic        fits, can_emit, saturated, rep_final;
   logic        step_req, step_fire;
   logic [2:0]  pop_n;
   logic [7:0]  step_byte;
   logic        end_msg, acc, new_pt;
   logic [3:0]  src;

   assign room      = (fq_cnt_ff != 2'd2);
   assign head      = win_ff[0];
   assign head_ctrl = (head >= pwsf_pkg::CTRL_FIRST) && (head <= pwsf_pkg::CTRL_LAST);
   assign can_emit  = (ocnt_ff < pwsf_pkg::MAX_LEN);
   assign saturated = flush_ff && !can_emit;
   assign rep_final = rep_ff && ({1'b0, rep_idx_ff} == (rep_len_ff - 4'd1));
   assign step_req  = in_msg_ff && !pass_ff && (rep_ff || (fill_ff == pwsf_pkg::WIN_FULL) || flush_ff);
   assign step_fire = step_req && room;

   // Pattern match against the window head
   always_comb begin
      logic [3:0] flen;
      logic       eq;
      logic [7:0] nx;
      for (int p = 0; p < pwsf_pkg::NUM_PAT; p++) begin
         flen = pwsf_pkg::PAT_FLEN[p];
         eq   = 1'b1;
         for (int i = 0; i < pwsf_pkg::WIN_DEPTH - 1; i++) begin
            if ((4'(i) < flen) &&
                (win_ff[i] != pwsf_pkg::pat_char(pwsf_pkg::PAT_FROM[p], 3'(i)))) begin
               eq = 1'b0;
            end
         end
         nx = (flen < fill_ff) ? win_ff[flen[2:0]] : 8'd0;
         pat_ok[p] = (flen <= fill_ff) && eq && !pwsf_pkg::is_letter(nx);
      end
   end

   // Longest pattern first: lowest index wins
   always_comb begin
      hit     = 1'b0;
      hit_pat = 3'd0;
      for (int p = pwsf_pkg::NUM_PAT - 1; p >= 0; p--) begin
         if (pat_ok[p]) begin
            hit     = 1'b1;
            hit_pat = 3'(p);
         end
      end
   end

   assign tl   = (mode_ff == pwsf_pkg::MODE_SHE) ? pwsf_pkg::PAT_SLEN[hit_pat]
                                                 : pwsf_pkg::PAT_TLEN[hit_pat];
   assign fits = (({1'b0, ocnt_ff} + {8'd0, tl}) <= {1'b0, pwsf_pkg::MAX_LEN});

   // Head step, window update and input acceptance
   always_comb begin
      mode_in    = mode_ff;
      in_msg_in  = in_msg_ff;
      pass_in    = pass_ff;
      flush_in   = flush_ff;
      prev_in    = prev_ff;
      args_in    = args_ff;
      ocnt_in    = ocnt_ff;
      rep_in     = rep_ff;
      rep_pat_in = rep_pat_ff;
      rep_idx_in = rep_idx_ff;
      rep_len_in = rep_len_ff;
      win_in     = win_ff;
      push       = 1'b0;
      push_word  = '{data: 8'd0, last: 1'b0};
      pop_n      = 3'd0;
      step_byte  = head;
      end_msg    = 1'b0;
      new_pt     = 1'b0;
      src        = 4'd0;

      // One head step: at most one output byte
      if (step_fire) begin
         if (saturated) begin
            push      = 1'b1;
            push_word = '{data: 8'd0, last: 1'b1};
            end_msg   = 1'b1;
         end else begin
            if (rep_ff) begin
               step_byte  = pwsf_pkg::pat_char(pwsf_pkg::rep_str(rep_pat_ff, mode_ff),
                                               rep_idx_ff);
               rep_idx_in = rep_idx_ff + 3'd1;
               if (rep_final) begin
                  pop_n   = pwsf_pkg::PAT_FLEN[rep_pat_ff][2:0];
                  rep_in  = 1'b0;
                  prev_in = 1'b1;
               end
            end else if (args_ff != 2'd0) begin
               args_in = args_ff - 2'd1;
               pop_n   = 3'd1;
            end else if (head_ctrl) begin
               args_in = pwsf_pkg::ARG_TABLE[head[4:0]];
               pop_n   = 3'd1;
            end else if (!prev_ff && hit && fits) begin
               step_byte  = pwsf_pkg::pat_char(pwsf_pkg::rep_str(hit_pat, mode_ff), 3'd0);
               rep_in     = 1'b1;
               rep_pat_in = hit_pat;
               rep_idx_in = 3'd1;
               rep_len_in = tl;
            end else begin
               prev_in = pwsf_pkg::is_letter(head);
               pop_n   = 3'd1;
            end
            // bytes past the cap are dropped
            if (can_emit) begin
               push      = 1'b1;
               push_word = '{data: step_byte, last: 1'b0};
               ocnt_in   = ocnt_ff + 11'd1;
            end
         end
      end

      fill_after = fill_ff - {1'b0, pop_n};

      // Draining ends at an empty window or when the cap is reached
      if (step_fire && !saturated && flush_ff &&
          (((fill_after == 4'd0) && !rep_in) ||
           (can_emit && ((ocnt_ff + 11'd1) == pwsf_pkg::MAX_LEN)))) begin
         push_word.last = 1'b1;
         end_msg        = 1'b1;
      end

      // Shift out popped bytes
      for (int i = 0; i < pwsf_pkg::WIN_DEPTH; i++) begin
         src = 4'(i) + {1'b0, pop_n};
         if (src < pwsf_pkg::WIN_FULL) begin
            win_in[i] = win_ff[src[2:0]];
         end
      end
      fill_in = fill_after;

      if (flush_ff) begin
         req_ready = 1'b0;
      end else if (!in_msg_ff || pass_ff) begin
         req_ready = room;
      end else begin
         req_ready = (fill_ff != pwsf_pkg::WIN_FULL) || (step_fire && (pop_n != 3'd0));
      end
      acc = req_valid && req_ready;

      // Accepted word
      if (acc) begin
         if (!in_msg_ff) begin
            new_pt    = (csr_mode_ff == pwsf_pkg::MODE_PASS) || (req_msg_length == 11'd0) ||
                        (req_msg_length > pwsf_pkg::MAX_LEN);
            in_msg_in = 1'b1;
            mode_in   = csr_mode_ff;
            pass_in   = new_pt;
         end
         if (new_pt || pass_ff) begin
            push      = 1'b1;
            push_word = '{data: req_in_byte, last: req_in_last};
            end_msg   = req_in_last;
         end else begin
            win_in[fill_after[2:0]] = req_in_byte;
            fill_in                 = fill_after + 4'd1;
            flush_in                = req_in_last;
         end
      end

      // Back to message start state
      if (end_msg) begin
         in_msg_in = 1'b0;
         pass_in   = 1'b0;
         flush_in  = 1'b0;
         prev_in   = 1'b0;
         args_in   = 2'd0;
         ocnt_in   = 11'd0;
         rep_in    = 1'b0;
         fill_in   = 4'd0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_mode_ff <= pwsf_pkg::MODE_PASS;
         in_msg_ff   <= 1'b0;
         pass_ff     <= 1'b0;
         flush_ff    <= 1'b0;
         prev_ff     <= 1'b0;
         args_ff     <= 2'd0;
         ocnt_ff     <= 11'd0;
         rep_ff      <= 1'b0;
         fill_ff     <= 4'd0;
      end else begin
         if (csr_we) begin
            csr_mode_ff <= csr_pronoun_mode;
         end
         in_msg_ff <= in_msg_in;
         pass_ff   <= pass_in;
         flush_ff  <= flush_in;
         prev_ff   <= prev_in;
         args_ff   <= args_in;
         ocnt_ff   <= ocnt_in;
         rep_ff    <= rep_in;
         fill_ff   <= fill_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      mode_ff    <= mode_in;
      rep_pat_ff <= rep_pat_in;
      rep_idx_ff <= rep_idx_in;
      rep_len_ff <= rep_len_in;
      win_ff     <= win_in;
   end

   // Output queue
   assign fq_pop       = (fq_cnt_ff != 2'd0) && rsp_ready;
   assign rsp_valid    = (fq_cnt_ff != 2'd0);
   assign rsp_out_byte = fq_ff[rd_ptr_ff].data;
   assign rsp_out_last = fq_ff[rd_ptr_ff].last;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fq_cnt_ff <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (fq_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         fq_cnt_ff <= fq_cnt_ff + {1'b0, push} - {1'b0, fq_pop};
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fq_ff[wr_ptr_ff] <= push_word;
      end
   end

   // Checks
   `PWSF_ASSERT_NOW(a_fill_range, clock, reset, 1'b1, fill_ff <= pwsf_pkg::WIN_FULL, "window overfilled")
   `PWSF_ASSERT_NOW(a_out_cap, clock, reset, 1'b1, ocnt_ff <= pwsf_pkg::MAX_LEN, "output count past cap")
   `PWSF_ASSERT_NOW(a_pass_idle, clock, reset, pass_ff, (fill_ff == 4'd0) && !rep_ff && !flush_ff, "pass-through with window busy")
   `PWSF_ASSERT_NOW(a_rep_stall, clock, reset, rep_ff && !rep_final, !req_ready, "input taken mid replacement")
   `PWSF_ASSERT_NEXT(a_last_ends, clock, reset, push && push_word.last, !in_msg_ff, "message still open after last word")

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

   localparam logic [1:0] MODE_THEY = 2'd2;
   localparam logic [1:0] MODE_ALT  = 2'd3;   // behaves as the they forms

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_pronoun_mode = pwsf_pkg::MODE_PASS;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_in_byte = 8'h00;
   logic [10:0] req_msg_length = 11'd0;
   logic        req_in_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_out_last;

   pronoun_word_substitution_filter dut (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_pronoun_mode (csr_pronoun_mode),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_in_byte      (req_in_byte),
      .req_msg_length   (req_msg_length),
      .req_in_last      (req_in_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_out_last     (rsp_out_last)
   );

   always #10 clock = ~clock;

   // Pronoun spellings and their replacements, longest first
   string pron_from [8] = '{"Himself", "himself", "Him", "him", "His", "his", "He", "he"};
   string pron_she  [8] = '{"Herself", "herself", "Her", "her", "Her", "her", "She", "she"};
   string pron_they [8] = '{"Themself", "themself", "Them", "them",
                            "Their", "their", "They", "they"};
   string plain_words [6] = '{"the", "she", "Hello", "They", "her", "hex"};

   // Argument bytes owed after each control code
   bit [1:0] ctrl_args [32] = '{
      0, 0, 0, 0, 0, 1, 1, 2,  0, 0, 0, 0, 1, 0, 1, 0,
      0, 2, 2, 1, 1, 3, 0, 0,  0, 0, 0, 0, 0, 0, 1, 0
   };

   // Directed stimulus; rows with typed set carry their expected word
   typedef struct packed {
      logic [1:0]  mode;
      logic [7:0]  data;
      logic [10:0] length;
      logic        last;
      logic        typed;
      logic [7:0]  want_data;
      logic        want_last;
   } probe_row_type;

   probe_row_type probe_rows [25] = '{
      // pass-through straight after reset, extremes of byte and length
      '{pwsf_pkg::MODE_PASS, 8'hFF, 11'd2047, 1'b1, 1'b1, 8'hFF, 1'b1},
      '{pwsf_pkg::MODE_PASS, 8'h00, 11'd0,    1'b1, 1'b1, 8'h00, 1'b1},
      // zero length forces pass-through even in they mode
      '{MODE_THEY, "h",   11'd0,    1'b0, 1'b1, "h",   1'b0},
      '{MODE_THEY, "e",   11'd0,    1'b1, 1'b1, "e",   1'b1},
      // length over the cap forces pass-through
      '{MODE_THEY, "H",   11'd1281, 1'b1, 1'b1, "H",   1'b1},
      // match closed by the end of the message, at the length limit
      '{MODE_THEY, "H",   11'd1280, 1'b0, 1'b0, 8'h00, 1'b0},
      '{MODE_THEY, "e",   11'd0,    1'b1, 1'b0, 8'h00, 1'b0},
      // longest pattern, full window
      '{MODE_THEY, "H",   11'd8,    1'b0, 1'b0, 8'h00, 1'b0},
      '{MODE_THEY, "i",   11'd8,    1'b0, 1'b0, 8'h00, 1'b0},
      '{MODE_THEY, "m",   11'd8,    1'b0, 1'b0, 8'h00, 1'b0},
      '{MODE_THEY, "s",   11'd8,    1'b0, 1'b0, 8'h00, 1'b0},
      '{MODE_THEY, "e",   11'd8,    1'b0, 1'b0, 8'h00, 1'b0},
      '{MODE_THEY, "l",   11'd8,    1'b0, 1'b0, 8'h00, 1'b0},
      '{MODE_THEY, "f",   11'd8,    1'b0, 1'b0, 8'h00, 1'b0},
      '{MODE_THEY, ".",   11'd8,    1'b1, 1'b0, 8'h00, 1'b0},
      // control code with three arguments that spell a pronoun
      '{MODE_THEY, 8'h15, 11'd7,    1'b0, 1'b0, 8'h00, 1'b0},
      '{MODE_THEY, "h",   11'd7,    1'b0, 1'b0, 8'h00, 1'b0},
      '{MODE_THEY, "i",   11'd7,    1'b0, 1'b0, 8'h00, 1'b0},
      '{MODE_THEY, "s",   11'd7,    1'b0, 1'b0, 8'h00, 1'b0},
      '{MODE_THEY, " ",   11'd7,    1'b0, 1'b0, 8'h00, 1'b0},
      '{MODE_THEY, "h",   11'd7,    1'b0, 1'b0, 8'h00, 1'b0},
      '{MODE_THEY, "e",   11'd7,    1'b1, 1'b0, 8'h00, 1'b0},
      // she forms
      '{pwsf_pkg::MODE_SHE,  "H",   11'd3,    1'b0, 1'b0, 8'h00, 1'b0},
      '{pwsf_pkg::MODE_SHE,  "i",   11'd3,    1'b0, 1'b0, 8'h00, 1'b0},
      '{pwsf_pkg::MODE_SHE,  "m",   11'd3,    1'b1, 1'b0, 8'h00, 1'b0}
   };

   logic [1:0] phase_modes [4] = '{pwsf_pkg::MODE_SHE, MODE_ALT, MODE_THEY,
                                   pwsf_pkg::MODE_PASS};

   // Rewrite state mirrored from the block
   logic [1:0]  mode_reg = pwsf_pkg::MODE_PASS;
   logic [1:0]  msg_mode = pwsf_pkg::MODE_PASS;
   logic [7:0]  win [8];
   int unsigned win_fill = 0;
   bit          prev_letter = 1'b0;
   int unsigned args_owed = 0;
   int unsigned out_total = 0;
   bit          passing = 1'b0;
   bit          in_message = 1'b0;

   pwsf_pkg::word_type step_out [$];       // words produced by the current input word
   pwsf_pkg::word_type pending_words [$];  // words still due from the block
   logic [7:0]  msg_bytes [$];             // message being sent

   int fail_count = 0;
   bit req_calm = 1'b0;
   bit rsp_calm = 1'b0;

   task automatic report_mismatch(input string what);
      fail_count++;
      $display("MISMATCH at %0t: %s", $time, what);
   endtask

   function automatic bit is_alpha(input logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
   endfunction

   function automatic void emit_byte(input logic [7:0] b);
      pwsf_pkg::word_type w;
      if (out_total < pwsf_pkg::MAX_LEN && step_out.size() < 16) begin
         w.data = b;
         w.last = 1'b0;
         step_out.push_back(w);
         out_total++;
      end
   endfunction

   function automatic void drop_head(input int unsigned n);
      if (n > win_fill)
         n = win_fill;
      for (int i = 0; i + n < win_fill; i++)
         win[i] = win[i + n];
      win_fill -= n;
   endfunction

   // Deal with the byte at the head of the window
   function automatic void rewrite_head();
      logic [7:0]  h;
      logic [7:0]  nx;
      string       pat;
      string       rep;
      int unsigned f;
      bit          hit;
      h = win[0];
      if (args_owed > 0) begin
         emit_byte(h);
         args_owed--;
         drop_head(1);
         return;
      end
      if (h >= pwsf_pkg::CTRL_FIRST && h <= pwsf_pkg::CTRL_LAST) begin
         emit_byte(h);
         args_owed = ctrl_args[h[4:0]];
         drop_head(1);
         return;
      end
      if (!prev_letter) begin
         for (int p = 0; p < 8; p++) begin
            pat = pron_from[p];
            f = pat.len();
            if (f > win_fill)
               continue;
            hit = 1'b1;
            for (int i = 0; i < f; i++)
               if (win[i] != pat[i])
                  hit = 1'b0;
            if (!hit)
               continue;
            nx = (f < win_fill) ? win[f] : 8'h00;
            if (is_alpha(nx))
               continue;
            rep = (msg_mode == pwsf_pkg::MODE_SHE) ? pron_she[p] : pron_they[p];
            // replacement would pass the cap: copy the byte instead
            if (out_total + rep.len() > pwsf_pkg::MAX_LEN)
               break;
            for (int i = 0; i < rep.len(); i++)
               emit_byte(rep[i]);
            drop_head(f);
            prev_letter = 1'b1;
            return;
         end
      end
      emit_byte(h);
      prev_letter = is_alpha(h);
      drop_head(1);
   endfunction

   function automatic void close_message();
      win_fill = 0;
      prev_letter = 1'b0;
      args_owed = 0;
      out_total = 0;
      passing = 1'b0;
      in_message = 1'b0;
   endfunction

   // Words due from one accepted input word, left in step_out
   function automatic void predict_rewrite(input logic [7:0] b, input logic [10:0] len,
                                           input logic lst);
      pwsf_pkg::word_type w;
      step_out.delete();
      if (!in_message) begin
         in_message = 1'b1;
         msg_mode = mode_reg;
         passing = (msg_mode == pwsf_pkg::MODE_PASS) || (len == 0) ||
                   (len > pwsf_pkg::MAX_LEN);
      end
      if (passing) begin
         w.data = b;
         w.last = lst;
         step_out.push_back(w);
         if (lst)
            close_message();
         return;
      end
      if (win_fill >= 8)
         rewrite_head();
      win[win_fill] = b;
      win_fill++;
      while (win_fill > 0 && (lst || win_fill >= 8))
         rewrite_head();
      if (lst) begin
         // cap reached with nothing left to send: a bare end mark
         if (step_out.size() == 0) begin
            w.data = 8'h00;
            w.last = 1'b1;
         end else begin
            w = step_out.pop_back();
            w.last = 1'b1;
         end
         step_out.push_back(w);
         close_message();
      end
   endfunction

   // Message content builders
   function automatic void add_text(input string s);
      for (int i = 0; i < s.len(); i++)
         msg_bytes.push_back(s[i]);
   endfunction

   function automatic logic [7:0] any_letter();
      logic [7:0] c;
      c = 8'h41 + 8'($urandom_range(0, 25));
      if ($urandom_range(0, 1) == 1)
         c = c + 8'h20;
      return c;
   endfunction

   function automatic void build_message(input int unsigned target);
      string       seps;
      string       w;
      int unsigned pick;
      logic [7:0]  code;
      seps = " .,!?'-";
      msg_bytes.delete();
      while (msg_bytes.size() < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            add_text(pron_from[$urandom_range(0, 7)]);
         end else if (pick < 45) begin
            // near misses: pronoun cut short or glued to a letter
            w = pron_from[$urandom_range(0, 7)];
            if ($urandom_range(0, 1) == 0) begin
               add_text(w.substr(0, w.len() - 2));
            end else begin
               add_text(w);
               msg_bytes.push_back(any_letter());
            end
         end else if (pick < 65) begin
            msg_bytes.push_back(seps[$urandom_range(0, seps.len() - 1)]);
         end else if (pick < 72) begin
            msg_bytes.push_back(any_letter());
         end else if (pick < 82) begin
            code = 8'($urandom_range(1, 31));
            msg_bytes.push_back(code);
            repeat (ctrl_args[code[4:0]])
               msg_bytes.push_back(($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 255))
                                                              : any_letter());
         end else if (pick < 92) begin
            msg_bytes.push_back(8'($urandom_range(0, 255)));
         end else begin
            add_text(plain_words[$urandom_range(0, 5)]);
         end
      end
   endfunction

   // Drive one input word and record the words it is due to produce
   task automatic send_word(input logic [7:0] b, input logic [10:0] len, input logic lst,
                            input bit typed, input pwsf_pkg::word_type want);
      int gap;
      if ($urandom_range(0, 31) == 0)
         req_calm = !req_calm;
      gap = req_calm ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_in_byte    <= b;
      req_msg_length <= len;
      req_in_last    <= lst;
      do @(posedge clock); while (!req_ready);
      predict_rewrite(b, len, lst);
      if (typed)
         pending_words.push_back(want);
      else
         foreach (step_out[i])
            pending_words.push_back(step_out[i]);
   endtask

   task automatic send_message(input logic [10:0] head_len);
      logic [10:0]        len;
      pwsf_pkg::word_type none;
      none = '0;
      for (int i = 0; i < msg_bytes.size(); i++) begin
         len = (i == 0) ? head_len : 11'($urandom_range(0, 2047));
         send_word(msg_bytes[i], len, i == msg_bytes.size() - 1, 1'b0, none);
      end
   endtask

   function automatic logic [10:0] pick_length();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r == 0)
         return 11'd0;
      else if (r == 1)
         return 11'($urandom_range(pwsf_pkg::MAX_LEN + 1, 2047));
      return 11'($urandom_range(1, pwsf_pkg::MAX_LEN));
   endfunction

   // Let the block drain before touching the mode register
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (24) @(posedge clock);
   endtask

   task automatic set_mode(input logic [1:0] m);
      csr_pronoun_mode <= m;
      csr_we <= 1'b1;
      @(posedge clock);
      csr_we <= 1'b0;
      mode_reg = m;
   endtask

   // Result side: random stalls between words
   initial begin : rsp_side
      int gap;
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 31) == 0)
            rsp_calm = !rsp_calm;
         gap = rsp_calm ? 0 : $urandom_range(0, 14);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   // Compare each word taken from the block with the oldest one due
   always @(posedge clock) begin : word_check
      pwsf_pkg::word_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_words.size() == 0) begin
            report_mismatch($sformatf("word %h last %b with nothing due",
                                      rsp_out_byte, rsp_out_last));
         end else begin
            due = pending_words.pop_front();
            if (rsp_out_byte !== due.data)
               report_mismatch($sformatf("byte %h, due %h", rsp_out_byte, due.data));
            if (rsp_out_last !== due.last)
               report_mismatch($sformatf("last %b, due %b (byte %h)",
                                         rsp_out_last, due.last, due.data));
         end
      end
   end

   initial begin : stimulus
      pwsf_pkg::word_type want;
      int unsigned        sent;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed rows
      foreach (probe_rows[r]) begin
         if (probe_rows[r].mode != mode_reg) begin
            settle();
            set_mode(probe_rows[r].mode);
         end
         want.data = probe_rows[r].want_data;
         want.last = probe_rows[r].want_last;
         send_word(probe_rows[r].data, probe_rows[r].length, probe_rows[r].last,
                   probe_rows[r].typed, want);
      end

      // random messages, one mode per phase
      foreach (phase_modes[ph]) begin
         settle();
         set_mode(phase_modes[ph]);
         sent = 0;
         while (sent < 40) begin
            build_message(($urandom_range(0, 3) == 0) ? $urandom_range(1, 3)
                                                     : $urandom_range(1, 24));
            send_message(pick_length());
            sent += msg_bytes.size();
         end
      end

      settle();
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin : watchdog
      #10ms;
      $display("TEST FAILED");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/pwsf_pkg.sv
hw/rtl/pronoun_word_substitution_filter.sv
sim/tb_top.sv
